/* rtl/ddwv_pkg.sv */
package ddwv_pkg;

    // default field widths
    localparam int COUNT_BITS_DEF = 16;
    localparam int SPEED_BITS_DEF = 32;

    // shared datapath width and iteration counter width
    localparam int DW    = 128;
    localparam int CNT_W = $clog2(DW + 1);

    // register and stamp widths
    localparam int TPR_W   = 16;
    localparam int RAD_W   = 20;
    localparam int BASE_W  = 22;
    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int REG_CNT = 3;
    localparam int PADDR_W = $clog2(REG_CNT) + 2;
    localparam int PDATA_W = 32;

    // reset values of the registers
    localparam logic [TPR_W-1:0]  TPR_RST  = TPR_W'(360);
    localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(50000);
    localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(200000);

    // arithmetic constants
    localparam int NS_BITS    = 30;
    localparam int MICRO_BITS = 20;
    localparam int LIN_SHIFT  = 33;
    localparam int BASE_SHIFT = 32;
    localparam logic [NS_BITS-1:0]    NS_PER_S   = NS_BITS'(1000000000);
    localparam logic [MICRO_BITS-1:0] MICRO      = MICRO_BITS'(1000000);
    localparam logic [34:0]           TWO_PI_Q32 = 35'd26986075409;
    // 1e9 * round(2*pi*2^32), folded once
    localparam logic [64:0]           K_RIM      = 65'(TWO_PI_Q32) * 65'(NS_PER_S);

    typedef enum logic [1:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_TICK
    } item_op_t;

    typedef enum logic [1:0] {
        REG_TPR,
        REG_RADIUS,
        REG_BASE
    } reg_idx_t;

    typedef enum logic [1:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_DIV
    } unit_op_t;

    typedef struct packed {
        logic              start;
        unit_op_t          op;
        logic [DW-1:0]     a;
        logic [DW-1:0]     b;
        logic [CNT_W-1:0]  n;
    } unit_req_t;

    typedef struct packed {
        logic [TPR_W-1:0]  tpr;
        logic [RAD_W-1:0]  radius;
        logic [BASE_W-1:0] base;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DN,
        ST_DS,
        ST_DTM,
        ST_DT,
        ST_DTABS,
        ST_DEN,
        ST_P,
        ST_NUM,
        ST_Q,
        ST_V,
        ST_SUM,
        ST_LIN,
        ST_DIFF,
        ST_DABS,
        ST_DM,
        ST_ANG,
        ST_EMIT
    } seq_state_t;

endpackage

/* rtl/ddwv_if.sv */
interface ddwv_in_if #(
    parameter int COUNT_BITS = ddwv_pkg::COUNT_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [COUNT_BITS-1:0] tick_change;
    logic [31:0]                  stamp_seconds;
    logic [29:0]                  stamp_nanoseconds;

    modport source (
        output valid, op, tick_change, stamp_seconds, stamp_nanoseconds,
        input  ready
    );
    modport sink (
        input  valid, op, tick_change, stamp_seconds, stamp_nanoseconds,
        output ready
    );
endinterface

interface ddwv_out_if #(
    parameter int SPEED_BITS = ddwv_pkg::SPEED_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] linear_speed;
    logic signed [SPEED_BITS-1:0] turn_rate;
    logic                         interval_fault;

    modport source (
        output valid, linear_speed, turn_rate, interval_fault,
        input  ready
    );
    modport sink (
        input  valid, linear_speed, turn_rate, interval_fault,
        output ready
    );
endinterface

/* rtl/ddwv_cfg.sv */
module ddwv_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddwv_pkg::PADDR_W-1:0]  paddr,
    input  logic [ddwv_pkg::PDATA_W-1:0]  pwdata,
    output logic [ddwv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ddwv_pkg::cfg_t                cfg
);
    import ddwv_pkg::*;

    logic [TPR_W-1:0]  tpr_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [BASE_W-1:0] base_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpr_reg    <= TPR_RST;
            radius_reg <= RAD_RST;
            base_reg   <= BASE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TPR:    tpr_reg    <= pwdata[TPR_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_BASE:   base_reg   <= pwdata[BASE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TPR:    prdata = PDATA_W'(tpr_reg);
            REG_RADIUS: prdata = PDATA_W'(radius_reg);
            REG_BASE:   prdata = PDATA_W'(base_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.tpr    = tpr_reg;
    assign cfg.radius = radius_reg;
    assign cfg.base   = base_reg;

endmodule

/* rtl/ddwv_unit.sv */
module ddwv_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ddwv_pkg::unit_req_t      req,
    output logic [ddwv_pkg::DW-1:0]  res,
    output logic                     done
);
    import ddwv_pkg::*;

    logic [DW-1:0]    acc_reg, acc_next;
    logic [DW-1:0]    dv_reg, dv_next;
    logic [DW-1:0]    y_reg, y_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             div_reg, div_next;
    logic             done_reg, done_next;

    logic [DW-1:0]    p_op, q_op;
    logic             sub;
    logic [DW:0]      sum_full;
    logic [DW-1:0]    sum;
    logic             carry;

    // the one adder: operands from the request, the product or the remainder
    always_comb
    begin
        if (!busy_reg)
        begin
            p_op = req.a;
            q_op = req.b;
            sub  = (req.op == UOP_SUB);
        end
        else if (div_reg)
        begin
            p_op = {rem_reg[DW-2:0], y_reg[DW-1]};
            q_op = dv_reg;
            sub  = 1'b1;
        end
        else
        begin
            p_op = acc_reg;
            q_op = dv_reg;
            sub  = 1'b0;
        end
        sum_full = {1'b0, p_op} + {1'b0, (sub ? ~q_op : q_op)} + {{DW{1'b0}}, sub};
        sum      = sum_full[DW-1:0];
        carry    = sum_full[DW];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        dv_next   = dv_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (!busy_reg && req.start)
        begin
            case (req.op)
                UOP_ADD, UOP_SUB:
                begin
                    acc_next  = sum;
                    done_next = 1'b1;
                end
                UOP_MUL:
                begin
                    dv_next   = req.a;
                    y_next    = req.b;
                    acc_next  = '0;
                    cnt_next  = req.n;
                    busy_next = 1'b1;
                    div_next  = 1'b0;
                end
                UOP_DIV:
                begin
                    // numerator arrives left aligned, one quotient bit per cycle
                    y_next    = req.a;
                    dv_next   = req.b;
                    rem_next  = '0;
                    acc_next  = '0;
                    cnt_next  = req.n;
                    busy_next = 1'b1;
                    div_next  = 1'b1;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next = carry ? sum : p_op;
                acc_next = {acc_reg[DW-2:0], carry};
                y_next   = y_reg << 1;
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = sum;
                end
                dv_next = dv_reg << 1;
                y_next  = y_reg >> 1;
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dv_reg  <= dv_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

    assign res  = acc_reg;
    assign done = done_reg;

endmodule

/* rtl/ddwv_seq.sv */
module ddwv_seq #(
    parameter int COUNT_BITS = ddwv_pkg::COUNT_BITS_DEF,
    parameter int SPEED_BITS = ddwv_pkg::SPEED_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    ddwv_in_if.sink                  items,
    ddwv_out_if.source               results,
    input  ddwv_pkg::cfg_t           cfg,
    output ddwv_pkg::unit_req_t      req,
    input  logic [ddwv_pkg::DW-1:0]  u_res,
    input  logic                     u_done
);
    import ddwv_pkg::*;

    localparam int P_BITS   = COUNT_BITS + RAD_W;
    localparam int NUM_BITS = COUNT_BITS + 84;

    // wheel history
    logic [SEC_W-1:0]      left_older_sec_reg, left_newer_sec_reg;
    logic [NSEC_W-1:0]     left_older_nsec_reg, left_newer_nsec_reg;
    logic [COUNT_BITS-1:0] left_change_reg;
    logic [1:0]            left_reports_reg;
    logic [SEC_W-1:0]      right_older_sec_reg, right_newer_sec_reg;
    logic [NSEC_W-1:0]     right_older_nsec_reg, right_newer_nsec_reg;
    logic [COUNT_BITS-1:0] right_change_reg;
    logic [1:0]            right_reports_reg;

    seq_state_t            state_reg, state_next;
    logic                  issued_reg, issued_next;
    logic                  side_reg, side_next;
    logic                  dneg_reg, dneg_next;
    logic                  neg_reg, neg_next;
    logic                  fault_reg, fault_next;
    logic [DW-1:0]         w0_reg, w0_next;
    logic [DW-1:0]         w1_reg, w1_next;
    logic [DW-1:0]         w2_reg, w2_next;
    logic [SPEED_BITS-1:0] lin_w_reg, lin_w_next;
    logic [SPEED_BITS-1:0] ang_w_reg, ang_w_next;
    logic [SPEED_BITS-1:0] lin_out_reg, ang_out_reg;
    logic                  fault_out_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  emit;

    logic                  accept;
    logic                  step_done;
    logic                  busy_state;
    logic [SEC_W-1:0]      sel_os, sel_ns;
    logic [NSEC_W-1:0]     sel_on, sel_nn;
    logic [COUNT_BITS-1:0] sel_chg, cm;
    logic                  cneg, vneg;
    logic [TPR_W-1:0]      tpr_eff;
    logic [BASE_W-1:0]     base_eff;

    function automatic logic [SPEED_BITS-1:0] sat_speed(input logic [DW-1:0] mag,
                                                        input logic neg);
        logic [DW-1:0]         lim;
        logic [DW-1:0]         bound;
        logic [DW-1:0]         m;
        logic [SPEED_BITS-1:0] ms;
        lim   = (DW'(1) << (SPEED_BITS - 1)) - DW'(1);
        bound = neg ? lim + DW'(1) : lim;
        m     = (mag > bound) ? bound : mag;
        ms    = m[SPEED_BITS-1:0];
        return neg ? (~ms + SPEED_BITS'(1)) : ms;
    endfunction

    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign step_done   = issued_reg && u_done;
    assign busy_state  = (state_reg != ST_IDLE) && (state_reg != ST_EMIT);

    assign sel_os  = side_reg ? right_older_sec_reg  : left_older_sec_reg;
    assign sel_ns  = side_reg ? right_newer_sec_reg  : left_newer_sec_reg;
    assign sel_on  = side_reg ? right_older_nsec_reg : left_older_nsec_reg;
    assign sel_nn  = side_reg ? right_newer_nsec_reg : left_newer_nsec_reg;
    assign sel_chg = side_reg ? right_change_reg     : left_change_reg;
    assign cm      = sel_chg[COUNT_BITS-1] ? (~sel_chg + COUNT_BITS'(1)) : sel_chg;
    // right wheel count runs the other way
    assign cneg    = side_reg ? (!sel_chg[COUNT_BITS-1] && (sel_chg != '0))
                              : sel_chg[COUNT_BITS-1];
    assign vneg     = cneg ^ dneg_reg;
    assign tpr_eff  = (cfg.tpr == '0) ? TPR_W'(1) : cfg.tpr;
    assign base_eff = (cfg.base == '0) ? BASE_W'(1) : cfg.base;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = busy_state ? (issued_reg ? !u_done : 1'b1) : 1'b0;
        side_next   = side_reg;
        dneg_next   = dneg_reg;
        neg_next    = neg_reg;
        fault_next  = fault_reg;
        w0_next     = w0_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        lin_w_next  = lin_w_reg;
        ang_w_next  = ang_w_reg;
        emit        = 1'b0;
        req         = '0;
        req.op      = UOP_ADD;
        req.start   = busy_state && !issued_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (items.op == OP_TICK) && left_reports_reg[1]
                    && right_reports_reg[1])
                begin
                    state_next = ST_DN;
                    side_next  = 1'b0;
                    fault_next = 1'b0;
                end
            end
            ST_DN:
            begin
                req.op = UOP_SUB;
                req.a  = DW'(sel_nn);
                req.b  = DW'(sel_on);
                if (step_done)
                begin
                    w0_next    = u_res;
                    state_next = ST_DS;
                end
            end
            ST_DS:
            begin
                req.op = UOP_SUB;
                req.a  = DW'(sel_ns);
                req.b  = DW'(sel_os);
                if (step_done)
                begin
                    state_next = ST_DTM;
                end
            end
            ST_DTM:
            begin
                req.op = UOP_MUL;
                req.a  = u_res;
                req.b  = DW'(NS_PER_S);
                req.n  = CNT_W'(NS_BITS);
                if (step_done)
                begin
                    state_next = ST_DT;
                end
            end
            ST_DT:
            begin
                req.op = UOP_ADD;
                req.a  = u_res;
                req.b  = w0_reg;
                if (step_done)
                begin
                    if (u_res == '0)
                    begin
                        fault_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        dneg_next  = u_res[DW-1];
                        state_next = ST_DTABS;
                    end
                end
            end
            ST_DTABS:
            begin
                req.op = u_res[DW-1] ? UOP_SUB : UOP_ADD;
                req.b  = u_res;
                if (step_done)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                req.op = UOP_MUL;
                req.a  = u_res;
                req.b  = DW'(tpr_eff);
                req.n  = CNT_W'(TPR_W);
                if (step_done)
                begin
                    w1_next    = u_res;
                    state_next = ST_P;
                end
            end
            ST_P:
            begin
                req.op = UOP_MUL;
                req.a  = DW'(cm);
                req.b  = DW'(cfg.radius);
                req.n  = CNT_W'(RAD_W);
                if (step_done)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                req.op = UOP_MUL;
                req.a  = DW'(K_RIM);
                req.b  = u_res;
                req.n  = CNT_W'(P_BITS);
                if (step_done)
                begin
                    state_next = ST_Q;
                end
            end
            ST_Q:
            begin
                req.op = UOP_DIV;
                req.a  = u_res << (DW - NUM_BITS);
                req.b  = w1_reg;
                req.n  = CNT_W'(NUM_BITS);
                if (step_done)
                begin
                    state_next = ST_V;
                end
            end
            ST_V:
            begin
                req.op = vneg ? UOP_SUB : UOP_ADD;
                req.b  = u_res;
                if (step_done)
                begin
                    if (!side_reg)
                    begin
                        w2_next    = u_res;
                        side_next  = 1'b1;
                        state_next = ST_DN;
                    end
                    else
                    begin
                        w0_next    = u_res;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                req.op = UOP_ADD;
                req.a  = w0_reg;
                req.b  = w2_reg;
                if (step_done)
                begin
                    neg_next   = u_res[DW-1];
                    state_next = ST_LIN;
                end
            end
            ST_LIN:
            begin
                req.op = u_res[DW-1] ? UOP_SUB : UOP_ADD;
                req.b  = u_res;
                if (step_done)
                begin
                    lin_w_next = sat_speed(u_res >> LIN_SHIFT, neg_reg);
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                req.op = UOP_SUB;
                req.a  = w0_reg;
                req.b  = w2_reg;
                if (step_done)
                begin
                    neg_next   = u_res[DW-1];
                    state_next = ST_DABS;
                end
            end
            ST_DABS:
            begin
                req.op = u_res[DW-1] ? UOP_SUB : UOP_ADD;
                req.b  = u_res;
                if (step_done)
                begin
                    state_next = ST_DM;
                end
            end
            ST_DM:
            begin
                req.op = UOP_MUL;
                req.a  = u_res;
                req.b  = DW'(MICRO);
                req.n  = CNT_W'(MICRO_BITS);
                if (step_done)
                begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG:
            begin
                req.op = UOP_DIV;
                req.a  = u_res;
                req.b  = DW'(base_eff) << BASE_SHIFT;
                req.n  = CNT_W'(DW);
                if (step_done)
                begin
                    ang_w_next = sat_speed(u_res, neg_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            issued_reg        <= 1'b0;
            side_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            left_reports_reg  <= '0;
            right_reports_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                case (items.op)
                    OP_LEFT:
                    begin
                        if (!left_reports_reg[1])
                        begin
                            left_reports_reg <= left_reports_reg + 2'd1;
                        end
                    end
                    OP_RIGHT:
                    begin
                        if (!right_reports_reg[1])
                        begin
                            right_reports_reg <= right_reports_reg + 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (items.op)
                OP_LEFT:
                begin
                    left_older_sec_reg  <= left_newer_sec_reg;
                    left_older_nsec_reg <= left_newer_nsec_reg;
                    left_newer_sec_reg  <= items.stamp_seconds;
                    left_newer_nsec_reg <= items.stamp_nanoseconds;
                    left_change_reg     <= items.tick_change;
                end
                OP_RIGHT:
                begin
                    right_older_sec_reg  <= right_newer_sec_reg;
                    right_older_nsec_reg <= right_newer_nsec_reg;
                    right_newer_sec_reg  <= items.stamp_seconds;
                    right_newer_nsec_reg <= items.stamp_nanoseconds;
                    right_change_reg     <= items.tick_change;
                end
                default: ;
            endcase
        end
        dneg_reg  <= dneg_next;
        neg_reg   <= neg_next;
        fault_reg <= fault_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        lin_w_reg <= lin_w_next;
        ang_w_reg <= ang_w_next;
        if (emit)
        begin
            lin_out_reg   <= fault_reg ? '0 : lin_w_reg;
            ang_out_reg   <= fault_reg ? '0 : ang_w_reg;
            fault_out_reg <= fault_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.linear_speed   = lin_out_reg;
    assign results.turn_rate      = ang_out_reg;
    assign results.interval_fault = fault_out_reg;

endmodule

/* rtl/diff_drive_wheel_velocity.sv */
// wheel odometry for a differential drive base
// items channel: op selects a left encoder report, a right encoder report or a
//   control tick; reports carry a signed tick change and a sec/nsec stamp
// results channel: linear speed (um/s), turn rate (urad/s), both saturated,
//   and interval_fault when a wheel interval is zero (speeds then 0)
// encoder reports give no result; a control tick gives a result only once
//   each wheel has had two reports, other codes are dropped
// a control tick runs through one shared 128-bit add/subtract unit that also
//   does bit-serial multiplies and divides; a zero interval ends it early
// items.ready is low while a tick is being worked on
// the result sits in an output register, so a stalled receiver only holds the
//   block once the next tick is done; reports are still taken while it is idle
// reset clears the report counts and restores the register defaults
// registers on the apb port: 0x0 ticks per revolution, 0x4 wheel radius,
//   0x8 wheel base; write them only while the block is idle
module diff_drive_wheel_velocity #(
    parameter int COUNT_BITS = ddwv_pkg::COUNT_BITS_DEF,
    parameter int SPEED_BITS = ddwv_pkg::SPEED_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ddwv_in_if.sink                       items,
    ddwv_out_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddwv_pkg::PADDR_W-1:0]  paddr,
    input  logic [ddwv_pkg::PDATA_W-1:0]  pwdata,
    output logic [ddwv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ddwv_pkg::*;

    cfg_t          cfg;
    unit_req_t     u_req;
    logic [DW-1:0] u_res;
    logic          u_done;

    ddwv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddwv_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .res   (u_res),
        .done  (u_done)
    );

    ddwv_seq #(
        .COUNT_BITS (COUNT_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg),
        .req     (u_req),
        .u_res   (u_res),
        .u_done  (u_done)
    );

endmodule
